// ===== src/timer_slot_pool_macros.svh =====
// timer_slot_pool_macros.svh: assertion shorthands for the timer slot pool.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef TIMER_SLOT_POOL_MACROS_SVH
`define TIMER_SLOT_POOL_MACROS_SVH

// same-cycle implication, checked outside reset
`define TSP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer_slot_pool assertion failed");

// next-cycle implication, checked outside reset
`define TSP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer_slot_pool assertion failed");

`endif

// ===== src/tsp_pkg.sv =====
// tsp_pkg: request codes, status codes and controller states of the timer slot pool.
// No dependencies.
package tsp_pkg;

	typedef enum logic [2:0] {
		CMD_TICK       = 3'd0,
		CMD_START_MEAS = 3'd1,
		CMD_END_MEAS   = 3'd2,
		CMD_START_TMR  = 3'd3,
		CMD_UPDATE     = 3'd4
	} cmd_code_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_NO_FREE  = 3'd1,
		STAT_BAD_SLOT = 3'd2,
		STAT_NOT_DUE  = 3'd3,
		STAT_FREED    = 3'd4
	} status_code_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} ctrl_state_t;

	localparam int SLOT_W   = 6;
	localparam int DUR_W    = 32;
	localparam int TAG_W    = 16;
	localparam int STATUS_W = 3;
	localparam int ELAPSED_W = 32;

endpackage

// ===== src/timer_slot_pool.sv =====
// timer_slot_pool: top level, controller with busy/action bits and slot memory.
// Uses tsp_pkg, tsp_ram, tsp_free_enc and timer_slot_pool_macros.svh.
//
// Usage:
//  Requests enter on in_valid/in_stall with cmd, slot, duration and tag.
//  Results leave on out_valid/out_stall with status, slot_out, elapsed,
//  fired and tag_out. Tick and unused codes give no result; every other
//  request gives exactly one.
//  Each request passes through an accept step, which also launches the
//  slot memory read for end-measure and update, and an execute step that
//  uses the read data, the registered free-slot encoder and the busy bits,
//  then writes the memory and the result register. No new request is
//  taken until the execute step of the one before it is done.
//  The result sits in an output register. While the receiver stalls, the
//  next request is still taken; its execute step waits until the output
//  register is emptied, and in_stall stays high meanwhile.
//  Reset clears the tick counter, all busy and action bits, the controller
//  and the output valid. Start time, duration and tag live in one RAM that
//  is not cleared: an entry is only read back while its slot is busy.
//  Elapsed time wraps with the TIME_BITS-bit tick counter.
`include "timer_slot_pool_macros.svh"

module timer_slot_pool
	import tsp_pkg::*;
#(
	parameter int NUM_SLOTS = 64,
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           cmd,
	input  logic [SLOT_W-1:0]    slot,
	input  logic [DUR_W-1:0]     duration,
	input  logic [TAG_W-1:0]     tag,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [STATUS_W-1:0]  status,
	output logic [SLOT_W-1:0]    slot_out,
	output logic [ELAPSED_W-1:0] elapsed,
	output logic                 fired,
	output logic [TAG_W-1:0]     tag_out
);

	localparam int IDX_W = $clog2(NUM_SLOTS);
	localparam int SW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
	localparam int EW    = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;
	localparam int RAM_W = TIME_BITS + DUR_W + TAG_W;

	ctrl_state_t state_q, state_d;

	logic [TIME_BITS-1:0] now_q;
	logic [NUM_SLOTS-1:0] busy_q;
	logic [NUM_SLOTS-1:0] act_q;

	// request held for the execute cycle
	logic [2:0]        cmd_q;
	logic [SLOT_W-1:0] slot_q;
	logic [DUR_W-1:0]  dur_q;
	logic [TAG_W-1:0]  tag_q;

	// output register
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [SLOT_W-1:0]    slot_out_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic                 fired_q;
	logic [TAG_W-1:0]     tag_out_q;

	logic accept;
	logic out_free;

	// free-slot search, registered
	logic             enc_found;
	logic [IDX_W-1:0] enc_idx;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [SW-1:0]    free_wide;

	// slot index decode
	logic [SW-1:0]    in_slot_wide;
	logic [IDX_W-1:0] in_idx;
	logic             in_range;
	logic [SW-1:0]    q_slot_wide;
	logic [IDX_W-1:0] q_idx;
	logic             q_range;
	logic             slot_live;

	// memory
	logic                 ram_we;
	logic                 ram_re;
	logic [RAM_W-1:0]     ram_wdata;
	logic [RAM_W-1:0]     ram_rdata;
	logic [TIME_BITS-1:0] rd_start;
	logic [DUR_W-1:0]     rd_dur;
	logic [TAG_W-1:0]     rd_tag;
	logic [TIME_BITS-1:0] el_t;
	logic [EW-1:0]        el_w;
	logic [EW-1:0]        dur_w;

	// execute decisions
	logic                 do_tick;
	logic                 set_busy;
	logic                 clr_busy;
	logic                 load_out;
	logic [STATUS_W-1:0]  res_status;
	logic [SLOT_W-1:0]    res_slot;
	logic [ELAPSED_W-1:0] res_elapsed;
	logic                 res_fired;
	logic [TAG_W-1:0]     res_tag;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign in_slot_wide = SW'(slot);
	assign in_idx       = in_slot_wide[IDX_W-1:0];
	assign in_range     = (32'(slot) < 32'(NUM_SLOTS));
	assign q_slot_wide  = SW'(slot_q);
	assign q_idx        = q_slot_wide[IDX_W-1:0];
	assign q_range      = (32'(slot_q) < 32'(NUM_SLOTS));
	assign slot_live    = q_range && busy_q[q_idx];
	assign free_wide    = SW'(free_idx_q);

	tsp_free_enc #(
		.NUM_SLOTS(NUM_SLOTS),
		.IDX_W    (IDX_W)
	) u_free_enc (
		.busy (busy_q),
		.found(enc_found),
		.idx  (enc_idx)
	);

	// read launched at accept so the data is there in the execute cycle
	assign ram_re    = accept && in_range &&
		((cmd == CMD_END_MEAS) || (cmd == CMD_UPDATE));
	assign ram_wdata = {now_q, dur_q, tag_q};

	tsp_ram #(
		.WIDTH(RAM_W),
		.DEPTH(NUM_SLOTS)
	) u_slot_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(free_idx_q),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(in_idx),
		.rd_data(ram_rdata)
	);

	assign rd_start = ram_rdata[RAM_W-1 -: TIME_BITS];
	assign rd_dur   = ram_rdata[TAG_W +: DUR_W];
	assign rd_tag   = ram_rdata[TAG_W-1:0];
	assign el_t     = now_q - rd_start;
	assign el_w     = EW'(el_t);
	assign dur_w    = EW'(rd_dur);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		do_tick     = 1'b0;
		set_busy    = 1'b0;
		clr_busy    = 1'b0;
		ram_we      = 1'b0;
		load_out    = 1'b0;
		res_status  = STAT_OK;
		res_slot    = slot_q;
		res_elapsed = '0;
		res_fired   = 1'b0;
		res_tag     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (cmd_q)
					CMD_TICK: begin
						do_tick = 1'b1;
						state_d = ST_IDLE;
					end
					CMD_START_MEAS, CMD_START_TMR: begin
						if (out_free) begin
							load_out = 1'b1;
							state_d  = ST_IDLE;
							if (free_found_q) begin
								ram_we   = 1'b1;
								set_busy = 1'b1;
								res_slot = free_wide[SLOT_W-1:0];
							end else begin
								res_status = STAT_NO_FREE;
								res_slot   = '0;
							end
						end
					end
					CMD_END_MEAS, CMD_UPDATE: begin
						if (out_free) begin
							load_out = 1'b1;
							state_d  = ST_IDLE;
							if (!slot_live) begin
								res_status = STAT_BAD_SLOT;
							end else if (cmd_q == CMD_END_MEAS) begin
								clr_busy    = 1'b1;
								res_elapsed = el_w[ELAPSED_W-1:0];
							end else if (!act_q[q_idx]) begin
								clr_busy   = 1'b1;
								res_status = STAT_FREED;
							end else if (el_w < dur_w) begin
								res_status = STAT_NOT_DUE;
							end else begin
								clr_busy  = 1'b1;
								res_fired = 1'b1;
								res_tag   = rd_tag;
							end
						end
					end
					default: begin
						// unused codes: dropped
						state_d = ST_IDLE;
					end
				endcase
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			slot_q <= slot;
			dur_q  <= duration;
			tag_q  <= tag;
		end
	end

	// tick counter, slot flags, free-slot register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q        <= '0;
			busy_q       <= '0;
			act_q        <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
		end else begin
			free_found_q <= enc_found;
			free_idx_q   <= enc_idx;
			if (do_tick) begin
				now_q <= now_q + 1'b1;
			end
			if (set_busy) begin
				busy_q[free_idx_q] <= 1'b1;
				act_q[free_idx_q]  <= (cmd_q == CMD_START_TMR);
			end
			if (clr_busy) begin
				busy_q[q_idx] <= 1'b0;
				act_q[q_idx]  <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q   <= res_status;
			slot_out_q <= res_slot;
			elapsed_q  <= res_elapsed;
			fired_q    <= res_fired;
			tag_out_q  <= res_tag;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign slot_out  = slot_out_q;
	assign elapsed   = elapsed_q;
	assign fired     = fired_q;
	assign tag_out   = tag_out_q;

	// a start only ever claims a slot that is free
	`TSP_ASSERT_NOW(a_alloc_free, ram_we, free_found_q && !busy_q[free_idx_q])
	// a claimed slot reads busy right after
	`TSP_ASSERT_NEXT(a_alloc_busy, set_busy, busy_q[$past(free_idx_q)])
	// a new result never overwrites one still waiting
	`TSP_ASSERT_NOW(a_no_overwrite, load_out, !out_valid_q || !out_stall)
	// a fired timer always reports ok and frees its slot
	`TSP_ASSERT_NOW(a_fire_frees, load_out && res_fired, clr_busy && res_status == STAT_OK)

endmodule

// ===== src/tsp_ram.sv =====
// tsp_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/tsp_free_enc.sv =====
// tsp_free_enc: priority encoder, lowest clear bit of the slot busy vector.
// Uses tsp_pkg.
module tsp_free_enc
	import tsp_pkg::*;
#(
	parameter int NUM_SLOTS = 64,
	parameter int IDX_W     = 6
) (
	input  logic [NUM_SLOTS-1:0] busy,
	output logic                 found,
	output logic [IDX_W-1:0]     idx
);

	// scan from the top so the lowest free slot wins
	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!busy[i]) begin
				found = 1'b1;
				idx   = IDX_W'(i);
			end
		end
	end

endmodule

// ===== bench/tb_timer_slot_pool.sv =====
// tb_timer_slot_pool: self-checking bench for the timer slot pool (directed table, then random).
// Depends on tsp_pkg and timer_slot_pool from the RTL; everything else is local.
// Results are predicted per accepted request and compared in order on the result channel.
module tb_timer_slot_pool;
	timeunit 1ns;
	timeprecision 1ps;
	import tsp_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int POOL_SLOTS   = 64;
	// counted random requests; the directed table adds 25 more
	localparam int RANDOM_ITEMS = 1425;
	// receiver hold-off for the fill-up stretch, and when it starts
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 400;
	// idle-cycle watchdog: the longest quiet stretch of a correct run is the hold-off
	// plus a sender gap plus the execute step
	localparam int IDLE_LIMIT   = 4000;
	localparam int TAIL_CYCLES  = 20;

	// request codes the block does not decode; it must drop them silently
	localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
	localparam logic [2:0] CMD_RSVD_MID   = 3'd6;
	localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;

	typedef struct packed {
		logic [2:0]        op;
		logic [SLOT_W-1:0] slot;
		logic [DUR_W-1:0]  dur;
		logic [TAG_W-1:0]  tag;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [SLOT_W-1:0]    slot;
		logic [ELAPSED_W-1:0] elapsed;
		logic                 fired;
		logic [TAG_W-1:0]     tag;
	} result_t;

	// one line of the directed table: request, plus a hand-written result where obvious
	typedef struct packed {
		request_t rq;
		logic     typed;
		result_t  want;
	} table_row_t;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                 in_valid;
	logic                 in_stall;
	logic [2:0]           cmd;
	logic [SLOT_W-1:0]    slot;
	logic [DUR_W-1:0]     duration;
	logic [TAG_W-1:0]     tag;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic [SLOT_W-1:0]    slot_out;
	logic [ELAPSED_W-1:0] elapsed;
	logic                 fired;
	logic [TAG_W-1:0]     tag_out;

	// shadow copy of the pool, updated at each request acceptance
	logic [31:0]      ticks_now;
	logic             slot_in_use   [POOL_SLOTS];
	logic             slot_is_timer [POOL_SLOTS];
	logic [31:0]      slot_t0       [POOL_SLOTS];
	logic [DUR_W-1:0] slot_len      [POOL_SLOTS];
	logic [TAG_W-1:0] slot_tagv     [POOL_SLOTS];

	result_t    pending_results [$];
	table_row_t directed_tbl [25];
	int         errors = 0;
	int         burst_left = 0;
	int         idle_cycles = 0;

	// receiver side state
	logic hold_off_go = 1'b0;
	logic hold_off_done = 1'b0;
	int   hold_left = 0;
	int   stall_mode_left = 0;
	int   stall_pct = 0;

	timer_slot_pool DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.slot     (slot),
		.duration (duration),
		.tag      (tag),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.slot_out (slot_out),
		.elapsed  (elapsed),
		.fired    (fired),
		.tag_out  (tag_out)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Apply one request to the shadow pool. Returns 1 when the block owes a result.
	function automatic logic pool_step(input request_t rq, output result_t res);
		int          free_idx;
		logic [31:0] since;
		res = '0;
		free_idx = -1;
		pool_step = 1'b1;
		case (rq.op)
		CMD_TICK: begin
			ticks_now = ticks_now + 32'd1;
			pool_step = 1'b0;
		end
		CMD_START_MEAS, CMD_START_TMR: begin
			// lowest free slot wins
			for (int i = POOL_SLOTS - 1; i >= 0; i--)
				if (!slot_in_use[i])
					free_idx = i;
			if (free_idx < 0) begin
				res.status = STAT_NO_FREE;
			end else begin
				slot_in_use[free_idx]   = 1'b1;
				slot_is_timer[free_idx] = (rq.op == CMD_START_TMR);
				slot_t0[free_idx]       = ticks_now;
				slot_len[free_idx]      = rq.dur;
				slot_tagv[free_idx]     = rq.tag;
				res.status = STAT_OK;
				res.slot   = SLOT_W'(free_idx);
			end
		end
		CMD_END_MEAS, CMD_UPDATE: begin
			res.slot = rq.slot;
			if (!slot_in_use[rq.slot]) begin
				res.status = STAT_BAD_SLOT;
			end else begin
				// wraps with the counter, so modulo arithmetic is the right answer
				since = ticks_now - slot_t0[rq.slot];
				if (rq.op == CMD_END_MEAS) begin
					// timer slots end like measures: no fire
					slot_in_use[rq.slot]   = 1'b0;
					slot_is_timer[rq.slot] = 1'b0;
					res.status  = STAT_OK;
					res.elapsed = since;
				end else if (!slot_is_timer[rq.slot]) begin
					slot_in_use[rq.slot] = 1'b0;
					res.status = STAT_FREED;
				end else if (since < slot_len[rq.slot]) begin
					res.status = STAT_NOT_DUE;
				end else begin
					slot_in_use[rq.slot]   = 1'b0;
					slot_is_timer[rq.slot] = 1'b0;
					res.status = STAT_OK;
					res.fired  = 1'b1;
					res.tag    = slot_tagv[rq.slot];
				end
			end
		end
		default: pool_step = 1'b0;
		endcase
	endfunction

	// Random request shaped by traffic mode. End/update mostly hit live slots.
	function automatic request_t random_request(input traffic_mode_t mode);
		request_t          rq;
		int                roll;
		int                th_tick, th_meas, th_tmr, th_end, th_upd;
		logic [SLOT_W-1:0] busy_list [$];
		case (mode)
		MODE_FILL:  begin th_tick = 15; th_meas = 45; th_tmr = 80; th_end = 88; th_upd = 96; end
		MODE_DRAIN: begin th_tick = 20; th_meas = 25; th_tmr = 30; th_end = 60; th_upd = 96; end
		default:    begin th_tick = 25; th_meas = 40; th_tmr = 60; th_end = 72; th_upd = 95; end
		endcase
		for (int i = 0; i < POOL_SLOTS; i++)
			if (slot_in_use[i])
				busy_list.push_back(SLOT_W'(i));
		rq.slot = SLOT_W'($urandom_range(0, POOL_SLOTS - 1));
		rq.tag  = TAG_W'($urandom);
		roll = $urandom_range(0, 99);
		// short durations so timers actually come due; some huge, some at the extremes
		if (roll < 50)
			rq.dur = DUR_W'($urandom_range(0, 8));
		else if (roll < 80)
			rq.dur = DUR_W'($urandom_range(0, 40));
		else if (roll < 95)
			rq.dur = DUR_W'($urandom);
		else
			rq.dur = $urandom_range(0, 1) ? '1 : '0;
		roll = $urandom_range(0, 99);
		if (roll < th_tick)
			rq.op = CMD_TICK;
		else if (roll < th_meas)
			rq.op = CMD_START_MEAS;
		else if (roll < th_tmr)
			rq.op = CMD_START_TMR;
		else if (roll < th_end)
			rq.op = CMD_END_MEAS;
		else if (roll < th_upd)
			rq.op = CMD_UPDATE;
		else
			rq.op = 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
		if ((rq.op == CMD_END_MEAS || rq.op == CMD_UPDATE) && busy_list.size() != 0
				&& $urandom_range(0, 99) < 85)
			rq.slot = busy_list[$urandom_range(0, busy_list.size() - 1)];
		return rq;
	endfunction

	// Sender pacing: bursts of back-to-back requests, then an occasional gap.
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Offer one request, hold it until taken, then predict its result.
	task automatic send_request(input request_t rq, input logic typed, input result_t typed_res);
		result_t res;
		in_valid <= 1'b1;
		cmd      <= rq.op;
		slot     <= rq.slot;
		duration <= rq.dur;
		tag      <= rq.tag;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		if (pool_step(rq, res))
			pending_results.push_back(typed ? typed_res : res);
		pace_sender();
	endtask

	// Result checker: in-order compare against the oldest pending expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: status %0d slot_out %0d", status, slot_out);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (slot_out !== want.slot) begin
					$error("slot_out: expected %0d, got %0d", want.slot, slot_out);
					errors++;
				end
				if (elapsed !== want.elapsed) begin
					$error("elapsed: expected %0d, got %0d", want.elapsed, elapsed);
					errors++;
				end
				if (fired !== want.fired) begin
					$error("fired: expected %0d, got %0d", want.fired, fired);
					errors++;
				end
				if (tag_out !== want.tag) begin
					$error("tag_out: expected %0h, got %0h", want.tag, tag_out);
					errors++;
				end
			end
		end
	end

	// Receiver: stall density changes every so often; once, a long hold-off lets the
	// block's output register fill so it has to push back on the request side.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_off_go && !hold_off_done) begin
			out_stall     <= 1'b1;
			hold_left     <= HOLD_CYCLES - 1;
			hold_off_done <= 1'b1;
		end else begin
			if (stall_mode_left == 0) begin
				stall_mode_left <= $urandom_range(20, 200);
				case ($urandom_range(0, 3))
				0: stall_pct <= 0;
				1: stall_pct <= 15;
				2: stall_pct <= 50;
				default: stall_pct <= 85;
				endcase
			end else begin
				stall_mode_left <= stall_mode_left - 1;
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Watchdog: too long without any handshake means a hang.
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timer_slot_pool test failed");
			$finish;
		end
	end

	initial begin
		request_t      rq;
		traffic_mode_t mode;
		int            mode_left;
		int            counted;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		cmd       = CMD_TICK;
		slot      = '0;
		duration  = '0;
		tag       = '0;
		ticks_now = '0;
		for (int i = 0; i < POOL_SLOTS; i++) begin
			slot_in_use[i]   = 1'b0;
			slot_is_timer[i] = 1'b0;
			slot_t0[i]       = '0;
			slot_len[i]      = '0;
			slot_tagv[i]     = '0;
		end

		// Directed table. Hand-written results only where they follow directly;
		// the rest (elapsed counts, late fires) come from the predictor.
		directed_tbl = '{
			// idle pool: both lookups report a bad slot
			'{'{CMD_UPDATE,     6'd0,  32'd0,          16'd0},      1'b1,
				'{STAT_BAD_SLOT, 6'd0,  32'd0, 1'b0, 16'd0}},
			'{'{CMD_END_MEAS,   6'd63, 32'd0,          16'd0},      1'b1,
				'{STAT_BAD_SLOT, 6'd63, 32'd0, 1'b0, 16'd0}},
			// first allocations go lowest-first; a measure ignores duration and tag
			'{'{CMD_START_MEAS, 6'd63, 32'hFFFF_FFFF,  16'hFFFF},   1'b1,
				'{STAT_OK,       6'd0,  32'd0, 1'b0, 16'd0}},
			'{'{CMD_START_TMR,  6'd0,  32'd0,          16'hFFFF},   1'b1,
				'{STAT_OK,       6'd1,  32'd0, 1'b0, 16'd0}},
			// zero duration fires right away
			'{'{CMD_UPDATE,     6'd1,  32'd0,          16'd0},      1'b1,
				'{STAT_OK,       6'd1,  32'd0, 1'b1, 16'hFFFF}},
			'{'{CMD_START_TMR,  6'd0,  32'hFFFF_FFFF,  16'd0},      1'b1,
				'{STAT_OK,       6'd1,  32'd0, 1'b0, 16'd0}},
			// longest duration is never due here
			'{'{CMD_UPDATE,     6'd1,  32'd0,          16'd0},      1'b1,
				'{STAT_NOT_DUE,  6'd1,  32'd0, 1'b0, 16'd0}},
			'{'{CMD_TICK,       6'd63, 32'hFFFF_FFFF,  16'hFFFF},   1'b0, '0},
			'{'{CMD_TICK,       6'd0,  32'd0,          16'd0},      1'b0, '0},
			'{'{CMD_END_MEAS,   6'd0,  32'd0,          16'd0},      1'b0, '0},
			// ending a timer slot as a measure: elapsed, no fire
			'{'{CMD_END_MEAS,   6'd1,  32'd0,          16'd0},      1'b0, '0},
			'{'{CMD_UPDATE,     6'd1,  32'd0,          16'd0},      1'b1,
				'{STAT_BAD_SLOT, 6'd1,  32'd0, 1'b0, 16'd0}},
			'{'{CMD_START_MEAS, 6'd0,  32'd0,          16'd0},      1'b1,
				'{STAT_OK,       6'd0,  32'd0, 1'b0, 16'd0}},
			// update on a measure slot just frees it
			'{'{CMD_UPDATE,     6'd0,  32'd0,          16'd0},      1'b1,
				'{STAT_FREED,    6'd0,  32'd0, 1'b0, 16'd0}},
			// unused codes, all other bits set: dropped without a result
			'{'{CMD_RSVD_FIRST, 6'd63, 32'hFFFF_FFFF,  16'hFFFF},   1'b0, '0},
			'{'{CMD_RSVD_MID,   6'd63, 32'hFFFF_FFFF,  16'hFFFF},   1'b0, '0},
			'{'{CMD_RSVD_LAST,  6'd63, 32'hFFFF_FFFF,  16'hFFFF},   1'b0, '0},
			'{'{CMD_START_TMR,  6'd0,  32'd3,          16'hA5A5},   1'b1,
				'{STAT_OK,       6'd0,  32'd0, 1'b0, 16'd0}},
			'{'{CMD_START_MEAS, 6'd0,  32'd0,          16'd0},      1'b1,
				'{STAT_OK,       6'd1,  32'd0, 1'b0, 16'd0}},
			'{'{CMD_UPDATE,     6'd0,  32'd0,          16'd0},      1'b1,
				'{STAT_NOT_DUE,  6'd0,  32'd0, 1'b0, 16'd0}},
			'{'{CMD_TICK,       6'd0,  32'd0,          16'd0},      1'b0, '0},
			'{'{CMD_TICK,       6'd0,  32'd0,          16'd0},      1'b0, '0},
			'{'{CMD_TICK,       6'd0,  32'd0,          16'd0},      1'b0, '0},
			// exactly due now
			'{'{CMD_UPDATE,     6'd0,  32'd0,          16'd0},      1'b0, '0},
			'{'{CMD_END_MEAS,   6'd1,  32'd0,          16'd0},      1'b0, '0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_tbl[i])
			send_request(directed_tbl[i].rq, directed_tbl[i].typed, directed_tbl[i].want);

		// Random traffic in episodes. The first one leans on allocation long enough
		// to run the pool dry; later ones pick fill, drain or mixed at random.
		mode      = MODE_FILL;
		mode_left = 150;
		counted   = 0;
		while (counted < RANDOM_ITEMS) begin
			if (mode_left == 0) begin
				mode      = traffic_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(30, 150);
			end
			mode_left--;
			rq = random_request(mode);
			counted++;
			if (counted == HOLD_AFTER)
				hold_off_go <= 1'b1;
			send_request(rq, 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("timer_slot_pool test passed");
		else
			$display("timer_slot_pool test failed");
		$finish;
	end

endmodule
